FILE: rtl/core/maf_pkg.sv
// ----------------------------------------------------------------------------
// MAC address filter package
// Shared types, constants and helpers for the filter table insert block.
// ----------------------------------------------------------------------------
package maf_pkg;

  // Table geometry.
  localparam int ENTRY_COUNT = 13;
  localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int ADDR_W      = 48;
  localparam int SLOT_W      = 4;

  // Multicast mapping: 01:00:5E followed by a zero bit and the group's low 23 bits.
  localparam logic [23:0] GROUP_OUI      = 24'h01005E;
  localparam int          GROUP_LOW_BITS = 23;

  // Command codes.
  localparam logic CMD_DIRECT = 1'b0;
  localparam logic CMD_GROUP  = 1'b1;

  // Outcome codes.
  localparam logic [1:0] OUTCOME_INSERTED = 2'd0;
  localparam logic [1:0] OUTCOME_PRESENT  = 2'd1;
  localparam logic [1:0] OUTCOME_FULL     = 2'd2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Input word.
  typedef struct packed {
    logic        cmd;
    logic [47:0] mac_address;
    logic [31:0] group_address;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [1:0]        outcome;
  } out_word_t;

  // Write request into the filter table.
  typedef struct packed {
    logic  en;
    idx_t  idx;
    addr_t data;
  } tbl_wr_t;

  // Entry number reduced to the width of the slot field.
  function automatic logic [SLOT_W-1:0] idx_to_slot(input idx_t idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

  // Address that a request asks to add.
  function automatic addr_t request_addr(input in_word_t w);
    addr_t a;
    if (w.cmd == CMD_GROUP) begin
      a = {GROUP_OUI, 1'b0, w.group_address[GROUP_LOW_BITS-1:0]};
    end else begin
      a = w.mac_address;
    end
    return a;
  endfunction

endpackage

FILE: rtl/core/maf_table.sv
// ----------------------------------------------------------------------------
// MAC address filter table storage
// Holds the filter addresses and their enable bits. A disabled entry reads
// as all zero, so reset only has to clear the enable mask.
// ----------------------------------------------------------------------------
module maf_table (
  input  logic              clk,
  input  logic              rst_n,
  input  maf_pkg::idx_t     rd_idx,
  output maf_pkg::addr_t    rd_entry,
  input  maf_pkg::tbl_wr_t  wr
);
  import maf_pkg::*;

  addr_t                  entries_r [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] enables_r;

  // Address storage; written only when an insert lands on an entry.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      entries_r[wr.idx] <= wr.data;
    end
  end

  // Enable mask, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r <= '0;
    end else if (wr.en) begin
      enables_r[wr.idx] <= 1'b1;
    end
  end

  // Single read port at the scan position.
  assign rd_entry = enables_r[rd_idx] ? entries_r[rd_idx] : '0;

endmodule

FILE: rtl/core/mac_address_filter_insert.sv
// ----------------------------------------------------------------------------
// MAC address filter insert
// Adds a direct or multicast-derived MAC address to a small filter table,
// scanning entries in order with one shared compare unit.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word        Contents
//   in_      input      in_word_t   cmd, mac_address, group_address
//   out_     output     out_word_t  slot, outcome
//
// An insert is accepted while idle and then scanned in order from entry 0;
// the scan visits one table entry per cycle through the single compare unit.
// in_ready is high only while idle.
// A finished result waits in the output register; a scan that ends while
// that register is still full holds until the word is taken.
// Reset clears the enable mask, which empties the whole table at once.
//
module mac_address_filter_insert (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  maf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output maf_pkg::out_word_t out_data
);
  import maf_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0] state_r, state_nxt;
  idx_t       idx_r, idx_nxt;
  addr_t      addr_r, addr_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;

  addr_t      entry;
  tbl_wr_t    wr;
  logic       hit;
  logic       empty;
  logic       last;
  logic       can_finish;

  maf_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r),
    .rd_entry (entry),
    .wr       (wr)
  );

  // Shared compare unit for the entry under the scan pointer.
  assign hit        = (entry == addr_r);
  assign empty      = (entry == '0);
  assign last       = (idx_r == IDX_W'(ENTRY_COUNT - 1));
  assign can_finish = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Scan sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr.en         = 1'b0;
    wr.idx        = idx_r;
    wr.data       = addr_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          addr_nxt  = request_addr(in_data);
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || empty || last) begin
          if (can_finish) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            if (hit) begin
              out_data_nxt.slot    = idx_to_slot(idx_r);
              out_data_nxt.outcome = OUTCOME_PRESENT;
            end else if (empty) begin
              wr.en                = 1'b1;
              out_data_nxt.slot    = idx_to_slot(idx_r);
              out_data_nxt.outcome = OUTCOME_INSERTED;
            end else begin
              out_data_nxt.slot    = '0;
              out_data_nxt.outcome = OUTCOME_FULL;
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
